[rtl/rgb_led_effect_sequencer_macros.svh]
// ---------------------------------------------------------------------------
// RGB LED effect sequencer assertion macros
// Assertion helpers used by the sequencer top level.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_EFFECT_SEQUENCER_MACROS_SVH
`define RGB_LED_EFFECT_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/rles_pkg.sv]
// ---------------------------------------------------------------------------
// RGB LED effect sequencer package
// Shared types, register indexes, mode codes and color helpers.
// ---------------------------------------------------------------------------
package rles_pkg;
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_BRIGHT = 3'd1;
  localparam logic [2:0] REG_COLOR1 = 3'd2;
  localparam logic [2:0] REG_COLOR2 = 3'd3;
  localparam logic [2:0] REG_COLOR3 = 3'd4;
  localparam logic [2:0] REG_MINPEAK = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;

  localparam logic [2:0] MODE_STATIC = 3'd0;
  localparam logic [2:0] MODE_BREATHE = 3'd1;
  localparam logic [2:0] MODE_CHANGE = 3'd2;
  localparam logic [2:0] MODE_RAINBOW = 3'd3;
  localparam logic [2:0] MODE_BLINK = 3'd4;
  localparam logic [2:0] MODE_EQ = 3'd5;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic start;
    logic [1:0] sel;
    logic update;
  } rles_cmd_t;

  typedef struct packed {
    logic div_done;
  } rles_sts_t;

  function automatic logic [23:0] pack_rgb(input logic [9:0] r, input logic [9:0] g,
                                           input logic [9:0] b);
    pack_rgb = {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [23:0] wheel_color(input logic [9:0] c);
    if (c < 10'd100) wheel_color = pack_rgb(10'd100, c, 10'd0);
    else if (c < 10'd200) wheel_color = pack_rgb(10'd200 - c, 10'd100, 10'd0);
    else if (c < 10'd300) wheel_color = pack_rgb(10'd0, 10'd100, c - 10'd200);
    else if (c < 10'd400) wheel_color = pack_rgb(10'd0, 10'd400 - c, 10'd100);
    else if (c < 10'd500) wheel_color = pack_rgb(c - 10'd400, 10'd0, 10'd100);
    else if (c <= 10'd600) wheel_color = pack_rgb(10'd100, 10'd0, 10'd600 - c);
    else wheel_color = pack_rgb(10'd100, 10'd0, 10'd0);
  endfunction

  function automatic logic [23:0] audio_color(input logic [9:0] c);
    if (c < 10'd100) audio_color = pack_rgb(10'd0, c, 10'd0);
    else if (c < 10'd200) audio_color = pack_rgb(c - 10'd100, 10'd200 - c, 10'd0);
    else if (c < 10'd300) audio_color = pack_rgb(10'd100, 10'd0, 10'd0);
    else if (c < 10'd400) audio_color = pack_rgb(10'd400 - c, 10'd0, c - 10'd300);
    else audio_color = pack_rgb(10'd0, 10'd0, 10'd100);
  endfunction
endpackage

[rtl/rles_ctrl.sv]
// ---------------------------------------------------------------------------
// RGB LED effect sequencer controller
// Sequences the three ratio divisions and the final state update.
// ---------------------------------------------------------------------------
module rles_ctrl import rles_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rles_cmd_t cmd,
  input  rles_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_UPD, S_OUT} state_t;
  state_t state_r;
  logic [1:0] sel_r;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.start = (state_r == S_START);
  assign cmd.sel = sel_r;
  assign cmd.update = (state_r == S_UPD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          state_r <= S_START;
          sel_r <= 2'd0;
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: if (sts.div_done) begin
          if (sel_r == 2'd2) state_r <= S_UPD;
          else begin
            sel_r <= sel_r + 2'd1;
            state_r <= S_START;
          end
        end
        S_UPD: state_r <= S_OUT;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/rles_datapath.sv]
// ---------------------------------------------------------------------------
// RGB LED effect sequencer datapath
// Configuration, effect state, a bit-serial divider and the result register.
// ---------------------------------------------------------------------------
module rles_datapath import rles_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  logic [LEVEL_BITS-1:0] in_peak_long,
  input  logic [LEVEL_BITS-1:0] in_peak_short,
  input  logic [LEVEL_BITS-1:0] in_peak_low_band,
  input  logic [LEVEL_BITS-1:0] in_peak_mid_band,
  input  logic [LEVEL_BITS-1:0] in_peak_high_band,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_data,
  input  rles_cmd_t             cmd,
  output rles_sts_t             sts,
  output logic [23:0]           pix_one,
  output logic [23:0]           pix_two,
  output logic [23:0]           pix_three,
  output logic [7:0]            bright
);
  localparam int NB = LEVEL_BITS + 10;
  localparam int DW = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam int CW = $clog2(NB + 1);

  logic [2:0] mode_r;
  logic [7:0] maxb_r, blev_r, bright_r;
  logic [15:0] minp_r, floor_r;
  logic [9:0] phase_r;
  logic [23:0] px_r [3];
  logic [LEVEL_BITS-1:0] long_r, lvl_r [3];
  logic [DW-1:0] div_r;
  logic [NB-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic busy_r;
  logic [9:0] rat_r [3];

  logic [DW-1:0] minp_ext, floor_ext, dv, diff;
  logic [LEVEL_BITS-1:0] lvl_sel, lvl_eff;
  logic [NB-1:0] num;
  logic [DW:0] trial;
  logic ge;
  logic [9:0] ph_c, ph_r, lv_dec;
  logic [7:0] blev_n;

  always_comb begin
    minp_ext = DW'(minp_r);
    floor_ext = DW'(floor_r);
    dv = (DW'(long_r) < minp_ext) ? minp_ext : DW'(long_r);
    if (dv == '0) dv = DW'(1);
    lvl_sel = (mode_r == MODE_BLINK) ? lvl_r[0] : lvl_r[cmd.sel];
    lvl_eff = (DW'(lvl_sel) < floor_ext) ? '0 : lvl_sel;
    num = NB'(lvl_eff) * NB'(600);
    trial = {rem_r, quo_r[NB-1]};
    ge = (trial >= {1'b0, div_r});
    diff = DW'(trial - {1'b0, div_r});
  end

  assign sts.div_done = busy_r && (cnt_r == CW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(NB);
    end else if (busy_r) begin
      if (cnt_r == CW'(0)) busy_r <= 1'b0;
      else cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo_r <= num;
      rem_r <= '0;
      div_r <= dv;
    end else if (busy_r && cnt_r != CW'(0)) begin
      if (ge) begin
        rem_r <= diff;
        quo_r <= {quo_r[NB-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[NB-2:0], 1'b0};
      end
    end else if (sts.div_done) begin
      rat_r[cmd.sel] <= (quo_r >= NB'(400)) ? 10'd400 : quo_r[9:0];
    end
    if (in_accept) begin
      long_r <= in_peak_long;
      lvl_r[0] <= (mode_r == MODE_BLINK) ? in_peak_short : in_peak_low_band;
      lvl_r[1] <= in_peak_mid_band;
      lvl_r[2] <= in_peak_high_band;
    end
  end

  always_comb begin
    ph_c = (phase_r >= 10'd600) ? 10'd0 : phase_r + 10'd1;
    ph_r = (phase_r >= 10'd300) ? 10'd0 : phase_r + 10'd1;
    blev_n = (phase_r == 10'd0) ? blev_r + 8'd1 : blev_r - 8'd1;
    lv_dec = 10'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STATIC;
      maxb_r <= 8'd0;
      minp_r <= 16'd1024;
      floor_r <= 16'd64;
      phase_r <= 10'd0;
      blev_r <= 8'd0;
      bright_r <= 8'd0;
      px_r[0] <= 24'd0;
      px_r[1] <= 24'd0;
      px_r[2] <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[2:0];
        REG_BRIGHT: maxb_r <= cfg_data[7:0];
        REG_COLOR1: px_r[0] <= cfg_data;
        REG_COLOR2: px_r[1] <= cfg_data;
        REG_COLOR3: px_r[2] <= cfg_data;
        REG_MINPEAK: minp_r <= cfg_data[15:0];
        REG_FLOOR: floor_r <= cfg_data[15:0];
        default: ;
      endcase
    end else if (cmd.update) begin
      bright_r <= (mode_r == MODE_BREATHE) ? blev_r : maxb_r;
      case (mode_r)
        MODE_STATIC: ;
        MODE_BREATHE: begin
          blev_r <= blev_n;
          if (blev_n >= maxb_r) phase_r <= 10'd1;
          else if (blev_n == 8'd0) phase_r <= lv_dec;
        end
        MODE_CHANGE: begin
          phase_r <= ph_c;
          px_r[0] <= wheel_color(ph_c);
          px_r[1] <= wheel_color(ph_c);
          px_r[2] <= wheel_color(ph_c);
        end
        MODE_RAINBOW: begin
          phase_r <= ph_r;
          if (ph_r < 10'd100) begin
            px_r[0] <= pack_rgb(10'd100 - ph_r, ph_r, 10'd0);
            px_r[1] <= pack_rgb(10'd0, 10'd100 - ph_r, ph_r);
            px_r[2] <= pack_rgb(ph_r, 10'd0, 10'd100 - ph_r);
          end else if (ph_r < 10'd200) begin
            px_r[0] <= pack_rgb(10'd0, 10'd200 - ph_r, ph_r - 10'd100);
            px_r[1] <= pack_rgb(ph_r - 10'd100, 10'd0, 10'd200 - ph_r);
            px_r[2] <= pack_rgb(10'd200 - ph_r, ph_r - 10'd100, 10'd0);
          end else begin
            px_r[0] <= pack_rgb(ph_r - 10'd200, 10'd0, 10'd300 - ph_r);
            px_r[1] <= pack_rgb(10'd300 - ph_r, ph_r - 10'd200, 10'd0);
            px_r[2] <= pack_rgb(10'd0, 10'd300 - ph_r, ph_r - 10'd200);
          end
        end
        MODE_BLINK: begin
          px_r[0] <= audio_color(rat_r[0]);
          px_r[1] <= audio_color(rat_r[0]);
          px_r[2] <= audio_color(rat_r[0]);
        end
        default: begin
          px_r[0] <= audio_color(rat_r[0]);
          px_r[1] <= audio_color(rat_r[1]);
          px_r[2] <= audio_color(rat_r[2]);
        end
      endcase
    end
  end

  assign pix_one = px_r[0];
  assign pix_two = px_r[1];
  assign pix_three = px_r[2];
  assign bright = bright_r;
endmodule

[rtl/rgb_led_effect_sequencer.sv]
// The bit-serial divider runs once per pixel, three times per input word, and a new
// word is accepted only after the last result has been taken: a waiting result holds
// off the input. Synchronous active-low reset restores register defaults and clears state.
// ---------------------------------------------------------------------------
// RGB LED effect sequencer
// Top level joining the controller and the datapath.
// ---------------------------------------------------------------------------
module rgb_led_effect_sequencer import rles_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LEVEL_BITS-1:0] in_peak_long,
  input  logic [LEVEL_BITS-1:0] in_peak_short,
  input  logic [LEVEL_BITS-1:0] in_peak_low_band,
  input  logic [LEVEL_BITS-1:0] in_peak_mid_band,
  input  logic [LEVEL_BITS-1:0] in_peak_high_band,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red_one,
  output logic [7:0]            out_green_one,
  output logic [7:0]            out_blue_one,
  output logic [7:0]            out_red_two,
  output logic [7:0]            out_green_two,
  output logic [7:0]            out_blue_two,
  output logic [7:0]            out_red_three,
  output logic [7:0]            out_green_three,
  output logic [7:0]            out_blue_three,
  output logic [7:0]            out_pixel_brightness,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_data
);
  `include "rgb_led_effect_sequencer_macros.svh"
  rles_cmd_t cmd;
  rles_sts_t sts;
  logic [23:0] p1, p2, p3;

  rles_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  rles_datapath #(.LEVEL_BITS(LEVEL_BITS)) u_dp (
    .clk, .rst_n, .in_accept(in_valid && in_ready), .in_peak_long, .in_peak_short,
    .in_peak_low_band, .in_peak_mid_band, .in_peak_high_band, .cfg_we, .cfg_index,
    .cfg_data, .cmd, .sts, .pix_one(p1), .pix_two(p2), .pix_three(p3),
    .bright(out_pixel_brightness)
  );

  assign {out_red_one, out_green_one, out_blue_one} = p1;
  assign {out_red_two, out_green_two, out_blue_two} = p2;
  assign {out_red_three, out_green_three, out_blue_three} = p3;

  `ASSERT_IMPL(a_ready_excl, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_start_upd, clk, rst_n, cmd.start, !cmd.update)
endmodule
